FILE: hdl/dalnf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dalnf_pkg;

  localparam int MINUTE_SLOTS  = 1440;
  localparam int WORD_W        = 32;
  localparam int MAP_WORDS     = MINUTE_SLOTS / WORD_W;
  localparam int WORD_AW       = $clog2(MAP_WORDS);
  localparam int BIT_W         = $clog2(WORD_W);
  localparam int SLOT_W        = WORD_AW + BIT_W;
  localparam int SCAN_EVALS    = MAP_WORDS + 1;
  localparam int EVAL_CNT_W    = $clog2(SCAN_EVALS + 1);

  localparam int HOUR_W        = 5;
  localparam int MIN_W         = 6;
  localparam int OFF_W         = 6;
  localparam int MINS_PER_HOUR = 60;
  localparam int LAST_HOUR     = 23;
  localparam int LAST_MINUTE   = 59;

  localparam int DIV_MUL       = 1093;
  localparam int DIV_SHIFT     = 16;
  localparam int PROD_W        = 22;

  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_FIRE = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [HOUR_W-1:0] set_hour;
    logic [MIN_W-1:0]  set_minute;
    logic [HOUR_W-1:0] now_hour;
    logic [MIN_W-1:0]  now_minute;
  } in_item_t;

  typedef struct packed {
    logic              alarm_armed;
    logic [HOUR_W-1:0] next_hour;
    logic [MIN_W-1:0]  next_minute;
    logic              vibrate;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic set_rd;
    logic set_wr;
    logic scan_issue;
    logic eval_en;
    logic eval_first;
    logic eval_last;
    logic res_clear;
    logic div;
    logic fix;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic set_req;
    logic hit;
  } stat_t;

endpackage

`default_nettype wire

FILE: hdl/dalnf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dalnf_in_if;
  logic                valid;
  logic                ready;
  dalnf_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/dalnf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dalnf_out_if;
  logic                 valid;
  logic                 ready;
  dalnf_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/dalnf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dalnf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/dalnf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dalnf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dalnf_pkg::stat_t  stat_i,
  output dalnf_pkg::cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SET_RD = 7'b0000010,
    S_SET_WR = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_FIX    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  localparam logic [dalnf_pkg::EVAL_CNT_W-1:0] EVALS =
    dalnf_pkg::EVAL_CNT_W'(dalnf_pkg::SCAN_EVALS);

  state_e                             state_q, state_d;
  logic [dalnf_pkg::EVAL_CNT_W-1:0]   issue_k_q, issue_k_d;
  logic [dalnf_pkg::EVAL_CNT_W-1:0]   eval_k_q, eval_k_d;
  logic                               eval_v_q, eval_v_d;
  logic                               out_valid_q, out_valid_d;
  dalnf_pkg::cmd_t                    cmd;

  always_comb begin
    state_d     = state_q;
    issue_k_d   = issue_k_q;
    eval_k_d    = eval_k_q;
    eval_v_d    = 1'b0;
    out_valid_d = out_valid_q;
    cmd         = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    cmd.eval_en    = (state_q == S_SCAN) && eval_v_q;
    cmd.eval_first = (eval_k_q == '0);
    cmd.eval_last  = (eval_k_q == EVALS - 1'b1);

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          issue_k_d  = '0;
          state_d    = stat_i.set_req ? S_SET_RD : S_SCAN;
        end
      end
      S_SET_RD: begin
        cmd.set_rd = 1'b1;
        state_d    = S_SET_WR;
      end
      S_SET_WR: begin
        cmd.set_wr = 1'b1;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        if (issue_k_q < EVALS) begin
          cmd.scan_issue = 1'b1;
          issue_k_d      = issue_k_q + 1'b1;
          eval_k_d       = issue_k_q;
          eval_v_d       = 1'b1;
        end
        if (cmd.eval_en) begin
          priority if (stat_i.hit) begin
            state_d  = S_DIV;
            eval_v_d = 1'b0;
          end else if (cmd.eval_last) begin
            cmd.res_clear = 1'b1;
            state_d       = S_DONE;
            eval_v_d      = 1'b0;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        state_d = S_FIX;
      end
      S_FIX: begin
        cmd.fix = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_k_q   <= '0;
      eval_k_q    <= '0;
      eval_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_k_q   <= issue_k_d;
      eval_k_q    <= eval_k_d;
      eval_v_q    <= eval_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> (state_q == S_SET_RD || state_q == S_SCAN))
    else $error("accepted beat did not start a set or a scan");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SET_WR) |-> ($past(state_q) == S_SET_RD))
    else $error("bitmap write without a preceding read");

  a_eval_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_v_q |-> (eval_k_q < EVALS))
    else $error("scan evaluated past the last word");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while holding a beat");

endmodule

`default_nettype wire

FILE: hdl/dalnf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module dalnf_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dalnf_pkg::cmd_t              cmd_i,
  output dalnf_pkg::stat_t             stat_o,
  input  dalnf_pkg::in_item_t          item_i,
  input  logic                         cfg_we_i,
  input  logic [dalnf_pkg::OFF_W-1:0]  cfg_wdata_i,
  output dalnf_pkg::out_item_t         result_o
);

  localparam int SW = dalnf_pkg::SLOT_W;
  localparam int AW = dalnf_pkg::WORD_AW;
  localparam int BW = dalnf_pkg::BIT_W;
  localparam int WW = dalnf_pkg::WORD_W;
  localparam int HW = dalnf_pkg::HOUR_W;
  localparam int MW = dalnf_pkg::MIN_W;

  logic [dalnf_pkg::OFF_W-1:0]     off_q;
  logic [dalnf_pkg::MAP_WORDS-1:0] valid_q;
  logic                            rd_valid_q;

  logic [SW-1:0] set_idx_q;
  logic [BW-1:0] sb_q;
  logic [AW-1:0] scan_word_q;
  logic [AW-1:0] eval_word_q;
  logic [SW-1:0] slot_q;
  logic [HW-1:0] hour_q;
  logic [MW-1:0] minute_q;
  logic          found_q;
  logic          vib_q;
  dalnf_pkg::out_item_t out_q;

  logic [SW-1:0] pos, pos1, start, set_idx;
  logic          set_ok;
  logic [AW-1:0] set_word, raddr;
  logic [WW-1:0] rdata, wdata, eff_word, lo_mask, masked;
  logic [BW-1:0] bit_idx;
  logic [dalnf_pkg::PROD_W-1:0] prod;
  logic [SW-1:0] hour60, rem;
  logic [MW-1:0] off_sat;
  logic [MW:0]   msum;

  assign pos  = SW'(item_i.now_hour) * SW'(dalnf_pkg::MINS_PER_HOUR) + SW'(item_i.now_minute);
  assign pos1 = pos + 1'b1;
  assign start = (pos1 >= SW'(dalnf_pkg::MINUTE_SLOTS)) ? '0 : pos1;

  assign set_idx = SW'(item_i.set_hour) * SW'(dalnf_pkg::MINS_PER_HOUR)
                 + SW'(item_i.set_minute);
  assign set_ok  = (item_i.req_type == dalnf_pkg::REQ_SET)
                && (item_i.set_hour <= HW'(dalnf_pkg::LAST_HOUR))
                && (item_i.set_minute <= MW'(dalnf_pkg::LAST_MINUTE));

  assign stat_o.set_req = set_ok;

  assign set_word = set_idx_q[SW-1:BW];
  assign raddr    = cmd_i.set_rd ? set_word : scan_word_q;
  assign eff_word = rd_valid_q ? rdata : '0;
  assign wdata    = eff_word | (WW'(1) << set_idx_q[BW-1:0]);

  dalnf_ram #(
    .WIDTH (dalnf_pkg::WORD_W),
    .DEPTH (dalnf_pkg::MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (cmd_i.set_wr),
    .waddr_i (set_word),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // first word keeps bits from the start, the wrap revisit keeps those below
  assign lo_mask = '1 << sb_q;
  always_comb begin
    priority if (cmd_i.eval_first) begin
      masked = eff_word & lo_mask;
    end else if (cmd_i.eval_last) begin
      masked = eff_word & ~lo_mask;
    end else begin
      masked = eff_word;
    end
  end

  always_comb begin
    bit_idx = '0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (masked[i]) begin
        bit_idx = BW'(i);
      end
    end
  end

  assign stat_o.hit = |masked;

  assign prod    = dalnf_pkg::PROD_W'(slot_q) * dalnf_pkg::PROD_W'(dalnf_pkg::DIV_MUL);
  assign hour60  = SW'(hour_q) * SW'(dalnf_pkg::MINS_PER_HOUR);
  assign rem     = slot_q - hour60;
  assign off_sat = (off_q > MW'(dalnf_pkg::LAST_MINUTE)) ? MW'(dalnf_pkg::LAST_MINUTE) : off_q;
  assign msum    = (MW + 1)'(rem[MW-1:0]) + (MW + 1)'(off_sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      valid_q <= '0;
    end else begin
      if (cfg_we_i) begin
        off_q <= cfg_wdata_i;
      end
      if (cmd_i.set_wr) begin
        valid_q[set_word] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_valid_q <= valid_q[raddr];
    if (cmd_i.accept) begin
      vib_q       <= item_i.req_type;
      set_idx_q   <= set_idx;
      sb_q        <= start[BW-1:0];
      scan_word_q <= start[SW-1:BW];
    end
    if (cmd_i.scan_issue) begin
      eval_word_q <= scan_word_q;
      scan_word_q <= (scan_word_q == AW'(dalnf_pkg::MAP_WORDS - 1)) ? '0
                   : scan_word_q + 1'b1;
    end
    if (cmd_i.eval_en && stat_o.hit) begin
      slot_q <= {eval_word_q, bit_idx};
    end
    if (cmd_i.res_clear) begin
      found_q  <= 1'b0;
      hour_q   <= '0;
      minute_q <= '0;
    end
    if (cmd_i.div) begin
      hour_q <= prod[dalnf_pkg::DIV_SHIFT +: HW];
    end
    if (cmd_i.fix) begin
      found_q <= 1'b1;
      if (msum >= (MW + 1)'(dalnf_pkg::MINS_PER_HOUR)) begin
        minute_q <= MW'(msum - (MW + 1)'(dalnf_pkg::MINS_PER_HOUR));
        hour_q   <= (hour_q >= HW'(dalnf_pkg::LAST_HOUR)) ? '0 : hour_q + 1'b1;
      end else begin
        minute_q <= msum[MW-1:0];
      end
    end
    if (cmd_i.out_load) begin
      out_q.alarm_armed <= found_q;
      out_q.next_hour   <= hour_q;
      out_q.next_minute <= minute_q;
      out_q.vibrate     <= vib_q;
    end
  end

  assign result_o = out_q;

endmodule

`default_nettype wire

FILE: hdl/daily_alarm_next_finder_unit.sv
// Next-alarm finder over a 1440-bit minute map held as 45 words of 32 bits in
// a registered-read RAM, with per-word valid flops so reset clears the map at
// once. A request beat sets one minute (set type with an in-range time) or
// reports a fired alarm, then the map is scanned circularly from the minute
// after the current time, one RAM word per cycle. After acceptance a set first
// reads and writes its map word; the scan then issues the first RAM read and
// evaluates up to 46 words (the start word is revisited at the end); a hit is
// followed by the hour/minute split, offset add and result load, a miss by the
// result load alone; a new request is taken the cycle after the result is
// registered, while the result may still wait at the output. The
// offset register is written through cfg_we_i/cfg_wdata_i and saturates at
// 59 when used.
`timescale 1ns / 1ps
`default_nettype none

module daily_alarm_next_finder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dalnf_in_if.sink                    req_i,
  dalnf_out_if.source                 rsp_o,
  input  logic                        cfg_we_i,
  input  logic [dalnf_pkg::OFF_W-1:0] cfg_wdata_i
);

  dalnf_pkg::cmd_t  cmd;
  dalnf_pkg::stat_t stat;

  dalnf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dalnf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .item_i      (req_i.data),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (rsp_o.data)
  );

endmodule

`default_nettype wire

FILE: tb/sv/daily_alarm_next_finder_unit_tb.sv
`timescale 1ns / 1ps

class alarm_scoreboard;
  bit                          minute_map[dalnf_pkg::MINUTE_SLOTS];
  logic [dalnf_pkg::OFF_W-1:0] offset;
  dalnf_pkg::out_item_t        next_alarm_q[$];
  int                          errors;
  int                          checked;
  int                          armed_cnt;
  int                          fired_cnt;
  int                          set_cnt;
  int                          bad_set_cnt;

  function new();
    offset      = '0;
    errors      = 0;
    checked     = 0;
    armed_cnt   = 0;
    fired_cnt   = 0;
    set_cnt     = 0;
    bad_set_cnt = 0;
  endfunction

  function void set_offset(logic [dalnf_pkg::OFF_W-1:0] value);
    offset = value;
  endfunction

  function int pending();
    return next_alarm_q.size();
  endfunction

  // update the minute map, then search circularly from the minute after now
  function void note_request(dalnf_pkg::in_item_t it);
    dalnf_pkg::out_item_t want;
    int pos;
    int last;
    int slot;
    int idx;
    int off;
    int hour;
    int minute;
    bit found;
    if (it.req_type == dalnf_pkg::REQ_SET) begin
      if (it.set_hour <= dalnf_pkg::LAST_HOUR && it.set_minute <= dalnf_pkg::LAST_MINUTE) begin
        minute_map[it.set_hour * dalnf_pkg::MINS_PER_HOUR + it.set_minute] = 1'b1;
        set_cnt++;
      end else begin
        bad_set_cnt++;
      end
    end else begin
      fired_cnt++;
    end
    pos   = it.now_hour * dalnf_pkg::MINS_PER_HOUR + it.now_minute;
    found = 1'b0;
    slot  = 0;
    for (idx = pos + 1; idx < dalnf_pkg::MINUTE_SLOTS && !found; idx++) begin
      if (minute_map[idx]) begin
        found = 1'b1;
        slot  = idx;
      end
    end
    last = (pos < dalnf_pkg::MINUTE_SLOTS) ? pos : dalnf_pkg::MINUTE_SLOTS - 1;
    for (idx = 0; idx <= last && !found; idx++) begin
      if (minute_map[idx]) begin
        found = 1'b1;
        slot  = idx;
      end
    end
    hour   = 0;
    minute = 0;
    if (found) begin
      off    = (offset > dalnf_pkg::LAST_MINUTE) ? dalnf_pkg::LAST_MINUTE : offset;
      hour   = slot / dalnf_pkg::MINS_PER_HOUR;
      minute = slot % dalnf_pkg::MINS_PER_HOUR + off;
      if (minute >= dalnf_pkg::MINS_PER_HOUR) begin
        minute -= dalnf_pkg::MINS_PER_HOUR;
        hour = (hour >= dalnf_pkg::LAST_HOUR) ? 0 : hour + 1;
      end
      armed_cnt++;
    end
    want.alarm_armed = found;
    want.next_hour   = hour[dalnf_pkg::HOUR_W-1:0];
    want.next_minute = minute[dalnf_pkg::MIN_W-1:0];
    want.vibrate     = it.req_type;
    next_alarm_q.push_back(want);
  endfunction

  task report_mismatch(string msg);
    $display("mismatch at result %0d: %s", checked, msg);
    errors++;
  endtask

  task check_result(dalnf_pkg::out_item_t got);
    dalnf_pkg::out_item_t want;
    if (next_alarm_q.size() == 0) begin
      report_mismatch("result beat with nothing expected");
      return;
    end
    want = next_alarm_q.pop_front();
    if (got.alarm_armed !== want.alarm_armed)
      report_mismatch($sformatf("alarm_armed %0b, want %0b", got.alarm_armed, want.alarm_armed));
    if (got.next_hour !== want.next_hour)
      report_mismatch($sformatf("next_hour %0d, want %0d", got.next_hour, want.next_hour));
    if (got.next_minute !== want.next_minute)
      report_mismatch($sformatf("next_minute %0d, want %0d", got.next_minute, want.next_minute));
    if (got.vibrate !== want.vibrate)
      report_mismatch($sformatf("vibrate %0b, want %0b", got.vibrate, want.vibrate));
    checked++;
  endtask
endclass

module daily_alarm_next_finder_unit_tb;
  import dalnf_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PHASE_ITEMS    = 250;
  localparam int RANDOM_PHASES  = 5;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AT_BEAT   = 300;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [OFF_W-1:0] cfg_wdata_i;

  dalnf_in_if  req_if ();
  dalnf_out_if rsp_if ();

  alarm_scoreboard alarm_sb = new();
  int              stall_cycles = 0;
  bit              src_quiet;
  bit              sink_quiet;

  daily_alarm_next_finder_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic in_item_t make_item(logic req, int sh, int sm, int nh, int nm);
    in_item_t it;
    it.req_type   = req;
    it.set_hour   = sh[HOUR_W-1:0];
    it.set_minute = sm[MIN_W-1:0];
    it.now_hour   = nh[HOUR_W-1:0];
    it.now_minute = nm[MIN_W-1:0];
    return it;
  endfunction

  // mostly in-range traffic with sparse sets, plus edge times and raw noise
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      it.req_type   = 1'($urandom_range(0, 1));
      it.set_hour   = HOUR_W'($urandom_range(0, 31));
      it.set_minute = MIN_W'($urandom_range(0, 63));
      it.now_hour   = HOUR_W'($urandom_range(0, 31));
      it.now_minute = MIN_W'($urandom_range(0, 63));
    end else begin
      it.req_type   = ($urandom_range(0, 4) == 0) ? REQ_SET : REQ_FIRE;
      it.set_hour   = HOUR_W'($urandom_range(0, LAST_HOUR));
      it.set_minute = MIN_W'($urandom_range(0, LAST_MINUTE));
      it.now_hour   = HOUR_W'($urandom_range(0, LAST_HOUR));
      it.now_minute = MIN_W'($urandom_range(0, LAST_MINUTE));
      if (pick < 30) begin
        case ($urandom_range(0, 3))
          0: begin
            it.now_hour   = '0;
            it.now_minute = '0;
          end
          1: begin
            it.now_hour   = HOUR_W'(LAST_HOUR);
            it.now_minute = MIN_W'(LAST_MINUTE);
          end
          2: begin
            it.now_hour   = HOUR_W'($urandom_range(LAST_HOUR + 1, 31));
            it.now_minute = MIN_W'($urandom_range(0, 63));
          end
          default: begin
            it.now_hour   = HOUR_W'($urandom_range(0, 31));
            it.now_minute = MIN_W'($urandom_range(LAST_MINUTE + 1, 63));
          end
        endcase
      end
    end
    return it;
  endfunction

  task automatic send_request(in_item_t it);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.data  = it;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    alarm_sb.note_request(it);
    @(negedge clk_i);
  endtask

  task automatic write_offset(int value);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value[OFF_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    alarm_sb.set_offset(value[OFF_W-1:0]);
  endtask

  task automatic settle();
    req_if.valid = 1'b0;
    while (alarm_sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // response side, with one long hold-off so the block backs up
  initial begin
    int wait_cycles;
    int beats;
    rsp_if.ready = 1'b0;
    beats        = 0;
    forever begin
      if (beats % 40 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
      wait_cycles = sink_quiet ? 0 : $urandom_range(0, 16);
      if (beats == HOLD_AT_BEAT) wait_cycles = LONG_HOLD;
      if (wait_cycles != 0) begin
        rsp_if.ready = 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      alarm_sb.check_result(rsp_if.data);
      beats++;
      @(negedge clk_i);
    end
  end

  initial begin
    int phase;
    int n;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    rst_ni       = 1'b0;
    src_quiet    = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_offset(0);
    // empty map, out-of-range set times
    send_request(make_item(REQ_FIRE, 0, 0, 12, 0));
    send_request(make_item(REQ_SET, 31, 63, 0, 0));
    send_request(make_item(REQ_SET, 24, 0, 31, 63));
    send_request(make_item(REQ_SET, 10, 60, 5, 5));
    // alarm at the current minute, found only after the wrap
    send_request(make_item(REQ_SET, 23, 59, 23, 59));
    send_request(make_item(REQ_SET, 0, 0, 23, 59));
    send_request(make_item(REQ_FIRE, 0, 0, 0, 0));
    send_request(make_item(REQ_SET, 12, 30, 12, 29));
    send_request(make_item(REQ_FIRE, 0, 0, 12, 30));
    // current time past the last slot or minute above 59
    send_request(make_item(REQ_FIRE, 0, 0, 31, 63));
    send_request(make_item(REQ_FIRE, 0, 0, 23, 60));
    send_request(make_item(REQ_FIRE, 0, 0, 0, 63));

    settle();
    write_offset(LAST_MINUTE);
    send_request(make_item(REQ_FIRE, 0, 0, 23, 0));
    send_request(make_item(REQ_FIRE, 0, 0, 12, 0));
    send_request(make_item(REQ_FIRE, 0, 0, 23, 59));

    // offset above 59 saturates
    settle();
    write_offset(63);
    send_request(make_item(REQ_FIRE, 0, 0, 23, 30));
    send_request(make_item(REQ_SET, 5, 1, 5, 0));

    settle();
    write_offset(1);
    send_request(make_item(REQ_FIRE, 0, 0, 23, 58));
    send_request(make_item(REQ_FIRE, 0, 0, 12, 20));

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: write_offset(60);
        1: write_offset($urandom_range(0, 63));
        2: write_offset(0);
        3: write_offset(30);
        default: write_offset($urandom_range(0, 63));
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) src_quiet = ($urandom_range(0, 3) == 0);
        send_request(random_item());
      end
    end

    req_if.valid = 1'b0;
    while (alarm_sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("checked %0d result beats over several offset settings, one long output stall",
             alarm_sb.checked);
    $display("requests: %0d sets, %0d out-of-range sets, %0d fired; %0d found an alarm",
             alarm_sb.set_cnt, alarm_sb.bad_set_cnt, alarm_sb.fired_cnt, alarm_sb.armed_cnt);
    if (alarm_sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
